>>> hw/rtl/amfm_pkg.sv
// ----------------------------------------------------------------------------
// amfm_pkg
// Shared widths, register indexes, mode codes, control structs and the
// quarter-wave sine generator for the sample modulator.
// ----------------------------------------------------------------------------
package amfm_pkg;

    localparam int DEFAULT_PHASE_WIDTH      = 32;
    localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;

    localparam int SAMPLE_WIDTH    = 10;
    localparam int CODE_WIDTH      = 8;
    localparam int MODE_WIDTH      = 2;
    localparam int STEP_WIDTH      = 32;
    localparam int SCALE_WIDTH     = 24;
    localparam int LEVEL_WIDTH     = 8;
    localparam int SINE_WIDTH      = 15;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int PROD_WIDTH      = LEVEL_WIDTH + SINE_WIDTH;
    localparam int QUOT_WIDTH      = 7;
    localparam int REM_WIDTH       = PROD_WIDTH - QUOT_WIDTH;

    localparam logic [MODE_WIDTH-1:0] MODE_AM  = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_FM  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_ASK = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_FSK = 2'd3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE            = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CARRIER_STEP    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPACE_STEP      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FM_PHASE_SCALE  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEVEL_THRESHOLD = 3'd4;

    localparam logic [MODE_WIDTH-1:0]  RST_MODE            = MODE_AM;
    localparam logic [STEP_WIDTH-1:0]  RST_CARRIER_STEP    = 32'd5368709;
    localparam logic [STEP_WIDTH-1:0]  RST_SPACE_STEP      = 32'd10737418;
    localparam logic [SCALE_WIDTH-1:0] RST_FM_PHASE_SCALE  = 24'd2680648;
    localparam logic [LEVEL_WIDTH-1:0] RST_LEVEL_THRESHOLD = 8'd128;

    localparam logic [SAMPLE_WIDTH:0]     LEVEL_DIVISOR = 11'd1023;
    localparam logic [LEVEL_WIDTH:0]      LEVEL_SPAN    = 9'd255;
    localparam logic [LEVEL_WIDTH-1:0]    FULL_SCALE    = 8'd255;
    localparam logic [REM_WIDTH:0]        CODE_DIVISOR  = 17'd65534;
    localparam logic [CODE_WIDTH-1:0]     CODE_MID      = 8'd128;
    localparam logic [CODE_WIDTH-1:0]     CODE_OFF      = 8'd127;

    typedef logic [1:0] phase_src_t;
    localparam phase_src_t SRC_CARRIER = 2'd0;
    localparam phase_src_t SRC_SPACE   = 2'd1;
    localparam phase_src_t SRC_FM_UP   = 2'd2;
    localparam phase_src_t SRC_FM_DOWN = 2'd3;

    typedef struct packed {
        phase_src_t             src;
        logic [LEVEL_WIDTH-1:0] fm_mag;
    } phase_ctrl_t;

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] factor_mag;
        logic                   factor_neg;
        logic                   floor_div;
        logic                   force_off;
    } code_ctrl_t;

    localparam int          Q_SHIFT     = 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << Q_SHIFT;
    localparam logic [63:0] SINE_MAX    = 64'd32767;

    typedef logic [8:0] series_div_t [8];
    localparam series_div_t SERIES_DIV = '{9'd6, 9'd20, 9'd42, 9'd72,
                                           9'd110, 9'd156, 9'd210, 9'd272};

    // round(32767 * sin(pi/2 * m / 2^depth_log2)) by a fixed-point series
    function automatic logic [SINE_WIDTH-1:0] quarter_sine(input int unsigned m,
                                                          input int unsigned depth_log2);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (HALF_PI_Q30 * 64'(m)) >> depth_log2;
        x2   = (x * x) >> Q_SHIFT;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> Q_SHIFT) / 64'(SERIES_DIV[n-1]);
            if ((n & 1) != 0)
            begin
                sum = (sum > term) ? sum - term : 64'd0;
            end
            else
            begin
                sum = sum + term;
            end
        end
        if (sum > Q30_ONE)
        begin
            sum = Q30_ONE;
        end
        v = (sum * SINE_MAX + (Q30_ONE >> 1)) >> Q_SHIFT;
        if (v > SINE_MAX)
        begin
            v = SINE_MAX;
        end
        return SINE_WIDTH'(v);
    endfunction

endpackage

>>> hw/rtl/amfm_level_div.sv
// ----------------------------------------------------------------------------
// amfm_level_div
// Serial restoring divide giving level = floor(255 * sample / 1023),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amfm_level_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [amfm_pkg::SAMPLE_WIDTH-1:0] sample,
    output logic [amfm_pkg::LEVEL_WIDTH-1:0]  level,
    output logic                              done
);

    localparam int LW        = amfm_pkg::LEVEL_WIDTH;
    localparam int SW        = amfm_pkg::SAMPLE_WIDTH;
    localparam int NUM_WIDTH = SW + LW;
    localparam int CNT_WIDTH = $clog2(LW);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(LW - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [LW-1:0]        low_reg, low_next;
    logic [LW-1:0]        quot_reg, quot_next;
    logic [NUM_WIDTH-1:0] scaled;
    logic [SW:0]          trial;
    logic                 ge;

    assign scaled = {sample, LW'(0)} - NUM_WIDTH'(sample);
    assign trial  = {rem_reg, low_reg[LW-1]};
    assign ge     = (trial >= amfm_pkg::LEVEL_DIVISOR);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = scaled[NUM_WIDTH-1:LW];
            low_next  = scaled[LW-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? SW'(trial - amfm_pkg::LEVEL_DIVISOR) : SW'(trial);
            low_next  = {low_reg[LW-2:0], 1'b0};
            quot_next = {quot_reg[LW-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign level = quot_reg;
    assign done  = done_reg;

endmodule

>>> hw/rtl/amfm_phase_serial.sv
// ----------------------------------------------------------------------------
// amfm_phase_serial
// Bit-serial phase unit: advances the carrier and space accumulators and
// forms the lookup phase (including the FM offset product) LSB first.
// ----------------------------------------------------------------------------
module amfm_phase_serial #(
    parameter int PHASE_WIDTH    = amfm_pkg::DEFAULT_PHASE_WIDTH,
    parameter int SINE_ADDR_BITS = $clog2(amfm_pkg::DEFAULT_SINE_TABLE_DEPTH)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  amfm_pkg::phase_ctrl_t            ctrl,
    input  logic [amfm_pkg::STEP_WIDTH-1:0]  carrier_step,
    input  logic [amfm_pkg::STEP_WIDTH-1:0]  space_step,
    input  logic [amfm_pkg::SCALE_WIDTH-1:0] fm_phase_scale,
    output logic [SINE_ADDR_BITS-1:0]        sine_phase,
    output logic                             done
);

    localparam int PW        = PHASE_WIDTH;
    localparam int LW        = amfm_pkg::LEVEL_WIDTH;
    localparam int CW        = amfm_pkg::SCALE_WIDTH;
    localparam int CNT_WIDTH = $clog2(PW);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(PW - 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_WIDTH-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]             carrier_reg, carrier_next;
    logic [PW-1:0]             space_reg, space_next;
    logic [PW-1:0]             cstep_reg, cstep_next;
    logic [PW-1:0]             sstep_reg, sstep_next;
    logic [CW-1:0]             scale_reg, scale_next;
    logic [LW:0]               macc_reg, macc_next;
    logic [LW-1:0]             mag_reg, mag_next;
    amfm_pkg::phase_src_t      src_reg, src_next;
    logic                      c_carry_reg, c_carry_next;
    logic                      s_carry_reg, s_carry_next;
    logic                      p_carry_reg, p_carry_next;
    logic [SINE_ADDR_BITS-1:0] top_reg, top_next;

    logic [1:0]  c_sum;
    logic [1:0]  s_sum;
    logic [1:0]  p_sum;
    logic [LW:0] macc_sum;
    logic        prod_bit;
    logic        addend_bit;
    logic        sel_bit;
    logic        fm_down;

    assign fm_down    = (src_reg == amfm_pkg::SRC_FM_DOWN);
    assign c_sum      = {1'b0, carrier_reg[0]} + {1'b0, cstep_reg[0]} + {1'b0, c_carry_reg};
    assign s_sum      = {1'b0, space_reg[0]} + {1'b0, sstep_reg[0]} + {1'b0, s_carry_reg};
    assign macc_sum   = macc_reg + (scale_reg[0] ? {1'b0, mag_reg} : '0);
    assign prod_bit   = macc_sum[0];
    assign addend_bit = fm_down ? ~prod_bit : prod_bit;
    assign p_sum      = {1'b0, carrier_reg[0]} + {1'b0, addend_bit} + {1'b0, p_carry_reg};

    always_comb
    begin
        unique case (src_reg)
            amfm_pkg::SRC_CARRIER: sel_bit = carrier_reg[0];
            amfm_pkg::SRC_SPACE:   sel_bit = space_reg[0];
            amfm_pkg::SRC_FM_UP:   sel_bit = p_sum[0];
            amfm_pkg::SRC_FM_DOWN: sel_bit = p_sum[0];
            default:               sel_bit = carrier_reg[0];
        endcase
    end

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        carrier_next = carrier_reg;
        space_next   = space_reg;
        cstep_next   = cstep_reg;
        sstep_next   = sstep_reg;
        scale_next   = scale_reg;
        macc_next    = macc_reg;
        mag_next     = mag_reg;
        src_next     = src_reg;
        c_carry_next = c_carry_reg;
        s_carry_next = s_carry_reg;
        p_carry_next = p_carry_reg;
        top_next     = top_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            cstep_next   = PW'(carrier_step);
            sstep_next   = PW'(space_step);
            scale_next   = fm_phase_scale;
            macc_next    = '0;
            mag_next     = ctrl.fm_mag;
            src_next     = ctrl.src;
            c_carry_next = 1'b0;
            s_carry_next = 1'b0;
            p_carry_next = (ctrl.src == amfm_pkg::SRC_FM_DOWN);
        end
        else if (busy_reg)
        begin
            carrier_next = {c_sum[0], carrier_reg[PW-1:1]};
            space_next   = {s_sum[0], space_reg[PW-1:1]};
            cstep_next   = {1'b0, cstep_reg[PW-1:1]};
            sstep_next   = {1'b0, sstep_reg[PW-1:1]};
            scale_next   = {1'b0, scale_reg[CW-1:1]};
            macc_next    = {1'b0, macc_sum[LW:1]};
            c_carry_next = c_sum[1];
            s_carry_next = s_sum[1];
            p_carry_next = p_sum[1];
            top_next     = {sel_bit, top_reg[SINE_ADDR_BITS-1:1]};
            cnt_next     = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            carrier_reg <= '0;
            space_reg   <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
            carrier_reg <= carrier_next;
            space_reg   <= space_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cstep_reg   <= cstep_next;
        sstep_reg   <= sstep_next;
        scale_reg   <= scale_next;
        macc_reg    <= macc_next;
        mag_reg     <= mag_next;
        src_reg     <= src_next;
        c_carry_reg <= c_carry_next;
        s_carry_reg <= s_carry_next;
        p_carry_reg <= p_carry_next;
        top_reg     <= top_next;
    end

    assign sine_phase = top_reg;
    assign done       = done_reg;

endmodule

>>> hw/rtl/amfm_sine_rom.sv
// ----------------------------------------------------------------------------
// amfm_sine_rom
// Quarter-wave sine table with symmetric folding and registered read,
// giving the Q0.15 magnitude and sign for a table phase.
// ----------------------------------------------------------------------------
module amfm_sine_rom #(
    parameter int SINE_TABLE_DEPTH = amfm_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  logic                             clk,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] phase,
    output logic [amfm_pkg::SINE_WIDTH-1:0]  sine_mag,
    output logic                             sine_neg
);

    localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER   = SINE_TABLE_DEPTH / 4;
    localparam int ENTRIES   = QUARTER + 1;
    localparam int IDX_BITS  = $clog2(ENTRIES);

    typedef logic [amfm_pkg::SINE_WIDTH-1:0] rom_t [ENTRIES];

    function automatic rom_t build_rom();
        rom_t t;
        for (int j = 0; j < ENTRIES; j++)
        begin
            t[j] = amfm_pkg::quarter_sine(4 * j, ADDR_BITS);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [ADDR_BITS-3:0]            frac;
    logic [IDX_BITS-1:0]             idx;
    logic [amfm_pkg::SINE_WIDTH-1:0] mag_reg;
    logic                            neg_reg;

    assign frac = phase[ADDR_BITS-3:0];
    assign idx  = phase[ADDR_BITS-2] ? IDX_BITS'(QUARTER) - {1'b0, frac} : {1'b0, frac};

    always_ff @(posedge clk)
    begin
        mag_reg <= SINE_ROM[idx];
        neg_reg <= phase[ADDR_BITS-1];
    end

    assign sine_mag = mag_reg;
    assign sine_neg = neg_reg;

endmodule

>>> hw/rtl/amfm_code_serial.sv
// ----------------------------------------------------------------------------
// amfm_code_serial
// Serial code unit: shift-add product of factor and sine magnitude, then a
// restoring divide by 65534, one bit per cycle, and the final DAC code.
// ----------------------------------------------------------------------------
module amfm_code_serial (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  amfm_pkg::code_ctrl_t             ctrl,
    input  logic [amfm_pkg::SINE_WIDTH-1:0]  sine_mag,
    input  logic                             sine_neg,
    output logic [amfm_pkg::CODE_WIDTH-1:0]  code,
    output logic                             done
);

    localparam int LW        = amfm_pkg::LEVEL_WIDTH;
    localparam int PW        = amfm_pkg::PROD_WIDTH;
    localparam int QW        = amfm_pkg::QUOT_WIDTH;
    localparam int RW        = amfm_pkg::REM_WIDTH;
    localparam int OW        = amfm_pkg::CODE_WIDTH;
    localparam int STEPS     = LW + QW;
    localparam int CNT_WIDTH = $clog2(STEPS);
    localparam logic [CNT_WIDTH-1:0] CNT_MUL_END = CNT_WIDTH'(LW);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST    = CNT_WIDTH'(STEPS - 1);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [CNT_WIDTH-1:0]            cnt_reg, cnt_next;
    logic [LW-1:0]                   factor_reg, factor_next;
    logic [amfm_pkg::SINE_WIDTH-1:0] smag_reg, smag_next;
    logic                            neg_reg, neg_next;
    logic                            floor_reg, floor_next;
    logic                            off_reg, off_next;
    logic [PW-1:0]                   acc_reg, acc_next;
    logic [QW-1:0]                   quot_reg, quot_next;
    logic [OW-1:0]                   code_reg, code_next;

    logic [RW:0]   trial;
    logic          ge;
    logic [RW-1:0] rem_new;
    logic [QW-1:0] quot_new;
    logic [OW-1:0] neg_mag;
    logic [OW-1:0] code_calc;

    assign trial    = acc_reg[PW-1:QW-1];
    assign ge       = (trial >= amfm_pkg::CODE_DIVISOR);
    assign rem_new  = ge ? RW'(trial - amfm_pkg::CODE_DIVISOR) : RW'(trial);
    assign quot_new = {quot_reg[QW-2:0], ge};
    assign neg_mag  = {1'b0, quot_new} + OW'(neg_reg & floor_reg & (rem_new != '0));

    always_comb
    begin
        priority if (off_reg)
        begin
            code_calc = amfm_pkg::CODE_OFF;
        end
        else if (neg_reg)
        begin
            code_calc = amfm_pkg::CODE_MID - neg_mag;
        end
        else
        begin
            code_calc = amfm_pkg::CODE_MID + {1'b0, quot_new};
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        factor_next = factor_reg;
        smag_next   = smag_reg;
        neg_next    = neg_reg;
        floor_next  = floor_reg;
        off_next    = off_reg;
        acc_next    = acc_reg;
        quot_next   = quot_reg;
        code_next   = code_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            factor_next = ctrl.factor_mag;
            smag_next   = sine_mag;
            neg_next    = ctrl.factor_neg ^ sine_neg;
            floor_next  = ctrl.floor_div;
            off_next    = ctrl.force_off;
            acc_next    = '0;
            quot_next   = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg < CNT_MUL_END)
            begin
                acc_next    = {acc_reg[PW-2:0], 1'b0}
                              + (factor_reg[LW-1] ? PW'(smag_reg) : '0);
                factor_next = {factor_reg[LW-2:0], 1'b0};
            end
            else
            begin
                acc_next  = {rem_new, acc_reg[QW-2:0], 1'b0};
                quot_next = quot_new;
            end
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                code_next = code_calc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        factor_reg <= factor_next;
        smag_reg   <= smag_next;
        neg_reg    <= neg_next;
        floor_reg  <= floor_next;
        off_reg    <= off_next;
        acc_reg    <= acc_next;
        quot_reg   <= quot_next;
        code_reg   <= code_next;
    end

    assign code = code_reg;
    assign done = done_reg;

endmodule

>>> hw/rtl/am_fm_ask_fsk_sample_modulator_top.sv
// ----------------------------------------------------------------------------
// am_fm_ask_fsk_sample_modulator_top
// AM / FM / ASK / FSK sample modulator: one ADC sample in, one DAC code out.
//
// channel  role    signals                                 transfer when
// in       sink    in_valid, in_stall, adc_sample          in_valid & !in_stall
// out      source  out_valid, out_stall, dac_code          out_valid & !out_stall
// cfg      sink    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// one sample occupies the block through the 8-step level divide, the
// bit-serial phase pass over PHASE_WIDTH bits, the sine table read and
// the 15-step multiply/divide code unit
// in_stall is high while a sample is in work
// reset zeroes both phase accumulators and loads the register defaults
// a result waits in the output register under out_stall; the next sample is
// still taken and its code waits in the code unit until that register frees
// ----------------------------------------------------------------------------
module am_fm_ask_fsk_sample_modulator_top #(
    parameter int PHASE_WIDTH      = amfm_pkg::DEFAULT_PHASE_WIDTH,
    parameter int SINE_TABLE_DEPTH = amfm_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [amfm_pkg::SAMPLE_WIDTH-1:0]    adc_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [amfm_pkg::CODE_WIDTH-1:0]      dac_code,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [amfm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [amfm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int SINE_ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int LW             = amfm_pkg::LEVEL_WIDTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LEVEL = 3'd1;
    localparam logic [2:0] ST_PHASE = 3'd2;
    localparam logic [2:0] ST_ROM   = 3'd3;
    localparam logic [2:0] ST_CODE  = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [amfm_pkg::MODE_WIDTH-1:0]  mode_reg;
    logic [amfm_pkg::STEP_WIDTH-1:0]  carrier_step_reg;
    logic [amfm_pkg::STEP_WIDTH-1:0]  space_step_reg;
    logic [amfm_pkg::SCALE_WIDTH-1:0] fm_phase_scale_reg;
    logic [LW-1:0]                    level_threshold_reg;

    logic                              out_valid_reg, out_valid_next;
    logic [amfm_pkg::CODE_WIDTH-1:0]   dac_code_reg;

    logic                              accept;
    logic                              level_done;
    logic                              phase_start;
    logic                              phase_done;
    logic                              code_start;
    logic                              code_done;
    logic                              load_out;
    logic [LW-1:0]                     level;
    logic [LW:0]                       two_level;
    logic [LW-1:0]                     level_mag;
    logic                              level_low;
    logic                              above;
    logic [SINE_ADDR_BITS-1:0]         sine_phase;
    logic [amfm_pkg::SINE_WIDTH-1:0]   sine_mag;
    logic                              sine_neg;
    logic [amfm_pkg::CODE_WIDTH-1:0]   code;
    amfm_pkg::phase_ctrl_t             phase_ctrl;
    amfm_pkg::code_ctrl_t              code_ctrl;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= amfm_pkg::RST_MODE;
            carrier_step_reg    <= amfm_pkg::RST_CARRIER_STEP;
            space_step_reg      <= amfm_pkg::RST_SPACE_STEP;
            fm_phase_scale_reg  <= amfm_pkg::RST_FM_PHASE_SCALE;
            level_threshold_reg <= amfm_pkg::RST_LEVEL_THRESHOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                amfm_pkg::REG_MODE:
                    mode_reg <= cfg_data[amfm_pkg::MODE_WIDTH-1:0];
                amfm_pkg::REG_CARRIER_STEP:
                    carrier_step_reg <= cfg_data[amfm_pkg::STEP_WIDTH-1:0];
                amfm_pkg::REG_SPACE_STEP:
                    space_step_reg <= cfg_data[amfm_pkg::STEP_WIDTH-1:0];
                amfm_pkg::REG_FM_PHASE_SCALE:
                    fm_phase_scale_reg <= cfg_data[amfm_pkg::SCALE_WIDTH-1:0];
                amfm_pkg::REG_LEVEL_THRESHOLD:
                    level_threshold_reg <= cfg_data[LW-1:0];
                default:
                    mode_reg <= mode_reg;
            endcase
        end
    end

    // level-derived control
    assign two_level = {level, 1'b0};
    assign level_low = !level[LW-1];
    assign level_mag = level_low ? LW'(amfm_pkg::LEVEL_SPAN - two_level)
                                 : LW'(two_level - amfm_pkg::LEVEL_SPAN);
    assign above     = (level > level_threshold_reg);

    always_comb
    begin
        phase_ctrl.fm_mag = level_mag;
        unique case (mode_reg)
            amfm_pkg::MODE_FM:
                phase_ctrl.src = level_low ? amfm_pkg::SRC_FM_DOWN : amfm_pkg::SRC_FM_UP;
            amfm_pkg::MODE_FSK:
                phase_ctrl.src = above ? amfm_pkg::SRC_CARRIER : amfm_pkg::SRC_SPACE;
            default:
                phase_ctrl.src = amfm_pkg::SRC_CARRIER;
        endcase
    end

    always_comb
    begin
        code_ctrl.factor_mag = amfm_pkg::FULL_SCALE;
        code_ctrl.factor_neg = 1'b0;
        code_ctrl.floor_div  = 1'b1;
        code_ctrl.force_off  = 1'b0;
        unique case (mode_reg)
            amfm_pkg::MODE_AM:
            begin
                code_ctrl.factor_mag = level_mag;
                code_ctrl.factor_neg = level_low;
            end
            amfm_pkg::MODE_FM:
                code_ctrl.floor_div = 1'b0;
            amfm_pkg::MODE_ASK:
                code_ctrl.force_off = !above;
            default:
                code_ctrl.force_off = 1'b0;
        endcase
    end

    // sequencer
    assign phase_start = (state_reg == ST_LEVEL) && level_done;
    assign code_start  = (state_reg == ST_ROM);
    assign load_out    = (state_reg == ST_HOLD) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept)     state_next = ST_LEVEL;
            ST_LEVEL: if (level_done) state_next = ST_PHASE;
            ST_PHASE: if (phase_done) state_next = ST_ROM;
            ST_ROM:                   state_next = ST_CODE;
            ST_CODE:  if (code_done)  state_next = ST_HOLD;
            ST_HOLD:  if (load_out)   state_next = ST_IDLE;
            default:                  state_next = ST_IDLE;
        endcase
    end

    // output register
    always_comb
    begin
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            dac_code_reg <= code;
        end
    end

    assign out_valid = out_valid_reg;
    assign dac_code  = dac_code_reg;

    amfm_level_div u_level_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sample (adc_sample),
        .level  (level),
        .done   (level_done)
    );

    amfm_phase_serial #(
        .PHASE_WIDTH    (PHASE_WIDTH),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_phase_serial (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (phase_start),
        .ctrl           (phase_ctrl),
        .carrier_step   (carrier_step_reg),
        .space_step     (space_step_reg),
        .fm_phase_scale (fm_phase_scale_reg),
        .sine_phase     (sine_phase),
        .done           (phase_done)
    );

    amfm_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk      (clk),
        .phase    (sine_phase),
        .sine_mag (sine_mag),
        .sine_neg (sine_neg)
    );

    amfm_code_serial u_code_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (code_start),
        .ctrl     (code_ctrl),
        .sine_mag (sine_mag),
        .sine_neg (sine_neg),
        .code     (code),
        .done     (code_done)
    );

endmodule
